### rtl/snor_pkg.sv
package snor_pkg;

    localparam int ADDR_W = 24;
    localparam int TICK_W = 20;
    localparam int ID_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [7:0] OP_NONE  = 8'h00;
    localparam logic [7:0] OP_PP    = 8'h02;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_SE    = 8'h20;
    localparam logic [7:0] OP_BE    = 8'hC7;
    localparam logic [7:0] OP_RDID  = 8'h9F;
    localparam logic [7:0] OP_RDUID = 8'h4B;

    localparam logic [7:0] BYTE_IDLE = 8'hFF;
    localparam logic [2:0] CNT_MAX = 3'd5;

    typedef enum logic [1:0] {
        CMD_SELECT   = 2'd0,
        CMD_XFER     = 2'd1,
        CMD_DESELECT = 2'd2,
        CMD_TICK     = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEVICE_ID   = 3'd0,
        REG_UNIQUE_ID   = 3'd1,
        REG_PROG_TICKS  = 3'd2,
        REG_SE_TICKS    = 3'd3,
        REG_BE_TICKS    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [ID_W-1:0]   device_id;
        logic [ID_W-1:0]   unique_id;
        logic [TICK_W-1:0] program_ticks;
        logic [TICK_W-1:0] sector_erase_ticks;
        logic [TICK_W-1:0] bulk_erase_ticks;
    } cfg_t;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

    function automatic logic [7:0] screen_opcode(input logic [7:0] op, input logic busy,
                                                 input logic wel);
        logic known;
        logic [7:0] res;
        known = (op == OP_PP) || (op == OP_READ) || (op == OP_RDSR) || (op == OP_WREN) ||
                (op == OP_SE) || (op == OP_BE) || (op == OP_RDID) || (op == OP_RDUID);
        res = op;
        if (!known)
            res = OP_NONE;
        else if (busy && op != OP_RDSR)
            res = OP_NONE;
        else if ((op == OP_PP || op == OP_SE || op == OP_BE) && !wel)
            res = OP_NONE;
        return res;
    endfunction

endpackage

### rtl/snor_if.sv
interface snor_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] mosi_byte;
    modport source (output valid, cmd, mosi_byte, input ready);
    modport sink (input valid, cmd, mosi_byte, output ready);
endinterface

interface snor_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] miso_byte;
    logic       busy_res;
    modport source (output valid, miso_byte, busy_res, input ready);
    modport sink (input valid, miso_byte, busy_res, output ready);
endinterface

interface snor_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/spi_nor_flash_device.sv
// serial nor flash device, one reply transaction for each event transaction
// an accepted event's reply is registered in the execute state once the output is free
// a new event is taken only after the last one commits (memory read-modify-write)
// sector erase stalls input for a sector sweep, bulk erase for a whole-array sweep
// after reset the whole array is swept to 0xff, no event taken meanwhile
// config registers take their defaults at reset and are written any cycle
module spi_nor_flash_device
    import snor_pkg::*;
#(
    parameter int MEM_BYTES = 65536,
    parameter int PAGE_BYTES = 256,
    parameter int SECTOR_BYTES = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    snor_in_if.sink    req,
    snor_out_if.source rsp,
    snor_cfg_if.sink   cfg
);
    // configuration register file
    cfg_t cfg_reg;
    mem_req_t mem_req;
    logic [7:0] mem_rdata;

    // config writes never stall
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_id <= 24'd13647895;
            cfg_reg.unique_id <= '0;
            cfg_reg.program_ticks <= 20'd16;
            cfg_reg.sector_erase_ticks <= 20'd256;
            cfg_reg.bulk_erase_ticks <= 20'd4096;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_DEVICE_ID:  cfg_reg.device_id <= cfg.data;
                REG_UNIQUE_ID:  cfg_reg.unique_id <= cfg.data;
                REG_PROG_TICKS: cfg_reg.program_ticks <= cfg.data[TICK_W-1:0];
                REG_SE_TICKS:   cfg_reg.sector_erase_ticks <= cfg.data[TICK_W-1:0];
                REG_BE_TICKS:   cfg_reg.bulk_erase_ticks <= cfg.data[TICK_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // frame sequencer, status and erase sweeps
    snor_ctrl #(
        .MEM_BYTES(MEM_BYTES),
        .PAGE_BYTES(PAGE_BYTES),
        .SECTOR_BYTES(SECTOR_BYTES)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp),
        .cfg(cfg_reg),
        .mem_req(mem_req),
        .mem_rdata(mem_rdata)
    );

    // flash array, one read or write port, registered read
    snor_mem #(
        .MEM_BYTES(MEM_BYTES)
    ) u_mem (
        .clk(clk),
        .req(mem_req),
        .rdata(mem_rdata)
    );

endmodule

### rtl/snor_mem.sv
module snor_mem
    import snor_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  logic       clk,
    input  mem_req_t   req,
    output logic [7:0] rdata
);
    localparam int AW = $clog2(MEM_BYTES);

    logic [7:0] mem [MEM_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.addr[AW-1:0]] <= req.wdata;
        end
        if (req.rd)
        begin
            rdata_reg <= mem[req.addr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/snor_ctrl.sv
module snor_ctrl
    import snor_pkg::*;
#(
    parameter int MEM_BYTES = 65536,
    parameter int PAGE_BYTES = 256,
    parameter int SECTOR_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    snor_in_if.sink     req,
    snor_out_if.source  rsp,
    input  cfg_t        cfg,
    output mem_req_t    mem_req,
    input  logic [7:0]  mem_rdata
);
    localparam int AW = $clog2(MEM_BYTES);
    localparam int PW = $clog2(PAGE_BYTES);
    localparam int SW = $clog2(SECTOR_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_SWEEP = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] cmd_reg;
    logic [7:0] byte_reg;
    logic [7:0] op_reg, op_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic wel_reg, wel_next;
    logic [TICK_W-1:0] busy_reg, busy_next;
    logic sel_reg, sel_next;
    logic [AW-1:0] sweep_addr_reg, sweep_addr_next;
    logic sweep_all_reg, sweep_all_next;
    logic out_valid_reg, out_valid_next;
    logic [7:0] miso_reg, miso_next;
    logic busy_res_reg;

    logic accept, out_free, commit, sweep_last, pp_write;
    logic [7:0] reply;

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;
    assign commit = (state_reg == ST_EXEC) && out_free;
    assign sweep_last = sweep_all_reg ? (&sweep_addr_reg) : (&sweep_addr_reg[SW-1:0]);

    always_comb
    begin
        op_next = op_reg;
        cnt_next = cnt_reg;
        addr_next = addr_reg;
        wel_next = wel_reg;
        busy_next = busy_reg;
        sel_next = sel_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_all_next = sweep_all_reg;
        state_next = state_reg;
        reply = BYTE_IDLE;
        pp_write = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                    case (cmd_t'(cmd_reg))
                        CMD_SELECT:
                        begin
                            sel_next = 1'b1;
                            cnt_next = '0;
                            op_next = OP_NONE;
                        end
                        CMD_XFER:
                        begin
                            if (sel_reg)
                            begin
                                if (cnt_reg == 3'd0)
                                    op_next = screen_opcode(byte_reg, busy_reg != '0, wel_reg);
                                else if (op_reg == OP_RDSR)
                                    reply = {6'd0, wel_reg, busy_reg != '0};
                                else if (cnt_reg <= 3'd3)
                                begin
                                    if (op_reg == OP_READ || op_reg == OP_PP || op_reg == OP_SE)
                                        addr_next = {addr_reg[ADDR_W-9:0], byte_reg};
                                    else if (op_reg == OP_RDID || op_reg == OP_RDUID)
                                    begin
                                        case (cnt_reg[1:0])
                                            2'd1: reply = (op_reg == OP_RDID) ?
                                                cfg.device_id[23:16] : cfg.unique_id[23:16];
                                            2'd2: reply = (op_reg == OP_RDID) ?
                                                cfg.device_id[15:8] : cfg.unique_id[15:8];
                                            default: reply = (op_reg == OP_RDID) ?
                                                cfg.device_id[7:0] : cfg.unique_id[7:0];
                                        endcase
                                    end
                                end
                                else if (op_reg == OP_READ)
                                begin
                                    reply = mem_rdata;
                                    addr_next = addr_reg + 24'd1;
                                end
                                else if (op_reg == OP_PP)
                                begin
                                    pp_write = 1'b1;
                                    addr_next = {addr_reg[ADDR_W-1:PW],
                                                 addr_reg[PW-1:0] + PW'(1)};
                                end
                                if (cnt_reg < CNT_MAX)
                                    cnt_next = cnt_reg + 3'd1;
                            end
                        end
                        CMD_DESELECT:
                        begin
                            if (sel_reg)
                            begin
                                case (op_reg)
                                    OP_WREN:
                                    begin
                                        if (cnt_reg == 3'd1)
                                            wel_next = 1'b1;
                                    end
                                    OP_BE:
                                    begin
                                        if (cnt_reg == 3'd1)
                                        begin
                                            wel_next = 1'b0;
                                            busy_next = cfg.bulk_erase_ticks;
                                            sweep_all_next = 1'b1;
                                            sweep_addr_next = '0;
                                            state_next = ST_SWEEP;
                                        end
                                    end
                                    OP_SE:
                                    begin
                                        if (cnt_reg == 3'd4)
                                        begin
                                            wel_next = 1'b0;
                                            busy_next = cfg.sector_erase_ticks;
                                            sweep_all_next = 1'b0;
                                            sweep_addr_next = {addr_reg[AW-1:SW], SW'(0)};
                                            state_next = ST_SWEEP;
                                        end
                                    end
                                    OP_PP:
                                    begin
                                        if (cnt_reg >= 3'd4)
                                        begin
                                            wel_next = 1'b0;
                                            busy_next = cfg.program_ticks;
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                                sel_next = 1'b0;
                                cnt_next = '0;
                                op_next = OP_NONE;
                            end
                        end
                        default:
                        begin
                            if (busy_reg != '0)
                                busy_next = busy_reg - TICK_W'(1);
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                sweep_addr_next = sweep_addr_reg + AW'(1);
                if (sweep_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_req.rd = accept;
        mem_req.wr = 1'b0;
        mem_req.addr = addr_reg;
        mem_req.wdata = BYTE_IDLE;
        if (state_reg == ST_SWEEP)
        begin
            mem_req.wr = 1'b1;
            mem_req.addr = ADDR_W'(sweep_addr_reg);
        end
        else if (pp_write)
        begin
            mem_req.wr = 1'b1;
            mem_req.wdata = mem_rdata & byte_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        miso_next = miso_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
            miso_next = reply;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            op_reg <= OP_NONE;
            cnt_reg <= '0;
            addr_reg <= '0;
            wel_reg <= 1'b0;
            busy_reg <= '0;
            sel_reg <= 1'b0;
            sweep_addr_reg <= '0;
            sweep_all_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            cnt_reg <= cnt_next;
            addr_reg <= addr_next;
            wel_reg <= wel_next;
            busy_reg <= busy_next;
            sel_reg <= sel_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_all_reg <= sweep_all_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.cmd;
            byte_reg <= req.mosi_byte;
        end
        if (commit)
        begin
            miso_reg <= miso_next;
            busy_res_reg <= (busy_next != '0);
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.miso_byte = miso_reg;
    assign rsp.busy_res = busy_res_reg;

    a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> !req.ready)
        else $error("item taken during erase sweep");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("frame byte count out of range");

    a_deselect_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !sel_reg |-> (cnt_reg == '0 && op_reg == OP_NONE))
        else $error("frame state left while deselected");

    a_busy_clears_wel: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg != '0 && $past(busy_reg) == '0) |-> !wel_reg)
        else $error("write enable latch kept on busy start");

endmodule

### tb/sv/spi_nor_flash_device_test.sv
`timescale 1ns / 100ps

module spi_nor_flash_device_test;
    import snor_pkg::*;

    // cycles with no transaction on any channel before the run is abandoned;
    // covers the reset sweep and a bulk erase stall with margin
    localparam int STALL_LIMIT = 200000;

    // shadow of the flash chip: array, frame state and id/timing registers
    class flash_scoreboard;
        typedef struct {
            logic [7:0] miso;
            logic       busy;
        } reply_t;

        logic [7:0]        mem [65536];
        logic [7:0]        opcode;
        logic [2:0]        nbytes;
        logic [23:0]       addr;
        logic              wel;
        logic [19:0]       busy_left;
        logic              selected;
        logic [23:0]       dev_id;
        logic [23:0]       uniq_id;
        logic [19:0]       pp_ticks;
        logic [19:0]       se_ticks;
        logic [19:0]       be_ticks;
        reply_t            replies [$];
        int                errors;

        function new();
            foreach (mem[i]) mem[i] = 8'hFF;
            opcode = OP_NONE;
            nbytes = '0;
            addr = '0;
            wel = 1'b0;
            busy_left = '0;
            selected = 1'b0;
            dev_id = 24'd13647895;
            uniq_id = '0;
            pp_ticks = 20'd16;
            se_ticks = 20'd256;
            be_ticks = 20'd4096;
            errors = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [23:0] value);
            case (idx)
                REG_DEVICE_ID:  dev_id = value;
                REG_UNIQUE_ID:  uniq_id = value;
                REG_PROG_TICKS: pp_ticks = value[19:0];
                REG_SE_TICKS:   se_ticks = value[19:0];
                REG_BE_TICKS:   be_ticks = value[19:0];
                default: ;
            endcase
        endfunction

        // opcode as latched: unknown, blocked by busy or missing write enable gives none
        function logic [7:0] latch_opcode(logic [7:0] op);
            logic known;
            known = op == OP_PP || op == OP_READ || op == OP_RDSR || op == OP_WREN ||
                    op == OP_SE || op == OP_BE || op == OP_RDID || op == OP_RDUID;
            if (!known || (busy_left != 0 && op != OP_RDSR))
                return OP_NONE;
            if ((op == OP_PP || op == OP_SE || op == OP_BE) && !wel)
                return OP_NONE;
            return op;
        endfunction

        function void commit();
            logic [15:0] base;
            case (opcode)
                OP_WREN:
                    if (nbytes == 1) wel = 1'b1;
                OP_BE:
                    if (nbytes == 1)
                    begin
                        foreach (mem[i]) mem[i] = 8'hFF;
                        wel = 1'b0;
                        busy_left = be_ticks;
                    end
                OP_SE:
                    if (nbytes == 4)
                    begin
                        base = {addr[15:12], 12'h000};
                        for (int i = 0; i < 4096; i++) mem[base + i] = 8'hFF;
                        wel = 1'b0;
                        busy_left = se_ticks;
                    end
                OP_PP:
                    if (nbytes >= 4)
                    begin
                        wel = 1'b0;
                        busy_left = pp_ticks;
                    end
                default: ;
            endcase
        endfunction

        function logic [7:0] shift_byte(logic [7:0] b);
            logic [7:0] reply;
            reply = 8'hFF;
            if (nbytes == 0)
                opcode = latch_opcode(b);
            else if (opcode == OP_RDSR)
                reply = {6'b0, wel, busy_left != 0};
            else if (nbytes <= 3)
            begin
                if (opcode == OP_READ || opcode == OP_PP || opcode == OP_SE)
                    addr = {addr[15:0], b};
                else if (opcode == OP_RDID)
                    reply = 8'(dev_id >> (8 * (3 - nbytes)));
                else if (opcode == OP_RDUID)
                    reply = 8'(uniq_id >> (8 * (3 - nbytes)));
            end
            else if (opcode == OP_READ)
            begin
                reply = mem[addr[15:0]];
                addr = addr + 24'd1;
            end
            else if (opcode == OP_PP)
            begin
                mem[addr[15:0]] = mem[addr[15:0]] & b;
                addr[7:0] = addr[7:0] + 8'd1;   // column wraps inside the page
            end
            if (nbytes < CNT_MAX) nbytes++;
            return reply;
        endfunction

        function void note_event(cmd_t c, logic [7:0] b);
            reply_t r;
            r.miso = 8'hFF;
            case (c)
                CMD_SELECT:
                begin
                    selected = 1'b1;
                    nbytes = '0;
                    opcode = OP_NONE;
                end
                CMD_XFER:
                    if (selected) r.miso = shift_byte(b);
                CMD_DESELECT:
                    if (selected)
                    begin
                        commit();
                        selected = 1'b0;
                        nbytes = '0;
                        opcode = OP_NONE;
                    end
                default:
                    if (busy_left != 0) busy_left--;
            endcase
            r.busy = busy_left != 0;
            replies.push_back(r);
        endfunction

        function void check_reply(logic [7:0] miso, logic busy);
            reply_t r;
            if (replies.size() == 0)
            begin
                $display("%0t: unexpected reply miso=%h busy=%b", $time, miso, busy);
                errors++;
                return;
            end
            r = replies.pop_front();
            if (miso !== r.miso)
            begin
                $display("%0t: miso_byte expected %h actual %h", $time, r.miso, miso);
                errors++;
            end
            if (busy !== r.busy)
            begin
                $display("%0t: busy_res expected %b actual %b", $time, r.busy, busy);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    snor_in_if  req_if ();
    snor_out_if rsp_if ();
    snor_cfg_if cfg_if ();

    spi_nor_flash_device dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    flash_scoreboard sb;
    int  n_sent;
    int  quiet_cycles;
    int  be_budget;
    bit  sender_idle_en;
    bit  receiver_idle_en;
    bit  long_hold;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog: counts cycles in which no transaction moves on any channel
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // reply monitor, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_reply(rsp_if.miso_byte, rsp_if.busy_res);
    end

    // receiver: random stall bursts, plus one long hold-off whenever requested
    initial
    begin
        rsp_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp_if.ready <= 1'b0;
                repeat (400) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (receiver_idle_en && $urandom_range(0, 11) == 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    // one event transaction; valid stays high between back-to-back events
    task automatic send_event(cmd_t c, logic [7:0] b);
        @(negedge clk);
        if (sender_idle_en && $urandom_range(0, 9) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.cmd <= c;
        req_if.mosi_byte <= b;
        do @(posedge clk); while (!req_if.ready);
        sb.note_event(c, b);
        n_sent++;
    endtask

    task automatic xfer(logic [7:0] b);
        send_event(CMD_XFER, b);
    endtask

    task automatic send_addr(logic [23:0] a);
        xfer(a[23:16]);
        xfer(a[15:8]);
        xfer(a[7:0]);
    endtask

    task automatic ticks(int n);
        repeat (n) send_event(CMD_TICK, 8'($urandom_range(0, 255)));
    endtask

    // opcode-only frame such as write enable or bulk erase
    task automatic short_frame(logic [7:0] op);
        send_event(CMD_SELECT, 8'($urandom_range(0, 255)));
        xfer(op);
        send_event(CMD_DESELECT, 8'($urandom_range(0, 255)));
    endtask

    // sender holds off until every reply has come back
    task automatic drain();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (sb.replies.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [23:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        do @(posedge clk); while (!cfg_if.ready);
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic write_all(logic [23:0] dev, logic [23:0] uid, logic [19:0] pp,
                             logic [19:0] se, logic [19:0] be);
        write_reg(REG_DEVICE_ID, dev);
        write_reg(REG_UNIQUE_ID, uid);
        write_reg(REG_PROG_TICKS, pp);
        write_reg(REG_SE_TICKS, se);
        write_reg(REG_BE_TICKS, be);
    endtask

    // addresses cluster in a few sectors so reads see programmed data;
    // the top byte is free, which exercises the modulo on the array index
    function automatic logic [23:0] pick_addr();
        logic [3:0] sector;
        case ($urandom_range(0, 2))
            0: sector = 4'h0;
            1: sector = 4'h1;
            default: sector = 4'hF;
        endcase
        return {8'($urandom_range(0, 255)), sector, 4'($urandom_range(0, 1)),
                8'($urandom_range(0, 255))};
    endfunction

    // one mostly well-formed frame with random content; some broken or noise
    task automatic random_frame();
        int pick;
        int n;
        bit broken;
        pick = $urandom_range(0, 99);
        broken = $urandom_range(0, 9) == 0;
        if (pick < 16)
            short_frame(OP_WREN);
        else if (pick < 38)
        begin
            if ($urandom_range(0, 4) != 0) short_frame(OP_WREN);
            // page program, occasionally long enough to wrap the column
            n = ($urandom_range(0, 29) == 0) ? $urandom_range(256, 270)
                                             : $urandom_range(0, 12);
            send_event(CMD_SELECT, 8'h00);
            xfer(OP_PP);
            send_addr(pick_addr());
            repeat (n) xfer(8'($urandom_range(0, 255)));
            send_event(CMD_DESELECT, 8'h00);
        end
        else if (pick < 43)
        begin
            short_frame(OP_WREN);
            send_event(CMD_SELECT, 8'h00);
            xfer(OP_SE);
            send_addr(pick_addr());
            if (broken) xfer(8'($urandom_range(0, 255)));
            send_event(CMD_DESELECT, 8'h00);
        end
        else if (pick < 44 && be_budget > 0)
        begin
            be_budget--;
            short_frame(OP_WREN);
            short_frame(OP_BE);
        end
        else if (pick < 62)
        begin
            send_event(CMD_SELECT, 8'h00);
            xfer(OP_READ);
            send_addr(($urandom_range(0, 7) == 0) ? 24'hFFFFFE : pick_addr());
            repeat ($urandom_range(0, 12)) xfer(8'($urandom_range(0, 255)));
            send_event(CMD_DESELECT, 8'h00);
        end
        else if (pick < 72)
        begin
            send_event(CMD_SELECT, 8'h00);
            xfer(OP_RDSR);
            repeat ($urandom_range(1, 4)) xfer(8'($urandom_range(0, 255)));
            send_event(CMD_DESELECT, 8'h00);
        end
        else if (pick < 78)
        begin
            send_event(CMD_SELECT, 8'h00);
            xfer($urandom_range(0, 1) ? OP_RDID : OP_RDUID);
            repeat ($urandom_range(1, 5)) xfer(8'($urandom_range(0, 255)));
            send_event(CMD_DESELECT, 8'h00);
        end
        else if (pick < 90)
            ticks($urandom_range(1, 30));
        else
        begin
            // raw noise: any command, any byte
            repeat ($urandom_range(1, 6))
                send_event(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_frames(int count);
        int target;
        target = n_sent + count;
        while (n_sent < target) random_frame();
    endtask

    initial
    begin
        sb = new();
        n_sent = 0;
        quiet_cycles = 0;
        be_budget = 3;
        sender_idle_en = 1'b1;
        receiver_idle_en = 1'b1;
        long_hold = 1'b0;
        req_if.valid = 1'b0;
        req_if.cmd = CMD_SELECT;
        req_if.mosi_byte = 8'h00;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_DEVICE_ID;
        cfg_if.data = '0;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // short busy times so the directed part can wait them out
        write_all(24'hC84017, 24'hA5C3E1, 20'd3, 20'd5, 20'd7);

        // directed: ids, status, program without and with write enable,
        // page wrap, read back, unknown opcode, stray events, reselect
        send_event(CMD_SELECT, 8'hFF);
        xfer(OP_RDID);
        send_addr(24'h000000);
        xfer(8'hFF);
        send_event(CMD_DESELECT, 8'h00);
        send_event(CMD_SELECT, 8'h00);
        xfer(OP_RDUID);
        send_addr(24'hFFFFFF);
        send_event(CMD_DESELECT, 8'h00);
        short_frame(OP_PP);                       // no write enable: ignored
        short_frame(OP_WREN);
        send_event(CMD_SELECT, 8'h00);
        xfer(OP_PP);
        send_addr(24'h0000FF);
        xfer(8'h00);
        xfer(8'h5A);                              // wraps to column zero
        send_event(CMD_DESELECT, 8'h00);
        send_event(CMD_SELECT, 8'h00);
        xfer(OP_RDSR);                            // busy while programming
        xfer(8'h00);
        send_event(CMD_DESELECT, 8'h00);
        ticks(4);
        send_event(CMD_SELECT, 8'h00);
        xfer(OP_READ);
        send_addr(24'h0000FF);
        xfer(8'h00);
        xfer(8'h00);
        send_event(CMD_SELECT, 8'h00);            // frame dropped by reselect
        xfer(8'h00);                              // unsupported opcode
        xfer(8'h12);
        send_event(CMD_DESELECT, 8'h00);
        send_event(CMD_DESELECT, 8'h00);          // already deselected
        xfer(8'hA5);                              // byte while deselected
        drain();

        run_frames(300);
        drain();

        // ids at their extremes, ticks at zero; receiver holds off while the sender keeps offering events
        write_all(24'h000000, 24'hFFFFFF, 20'd0, 20'd0, 20'd0);
        long_hold = 1'b1;
        run_frames(250);
        drain();

        write_all(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                  20'($urandom_range(1, 40)), 20'($urandom_range(1, 40)),
                  20'($urandom_range(1, 40)));
        long_hold = 1'b1;
        run_frames(350);
        drain();

        // last part: no idling, device id and busy times at their maximum, unique id at zero
        sender_idle_en = 1'b0;
        receiver_idle_en = 1'b0;
        write_all(24'hFFFFFF, 24'h000000, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        run_frames(300);

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.replies.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
rtl/snor_pkg.sv
rtl/snor_if.sv
rtl/snor_mem.sv
rtl/snor_ctrl.sv
rtl/spi_nor_flash_device.sv
tb/sv/spi_nor_flash_device_test.sv
